// File: rtl/core/gjd_pkg.sv
package gjd_pkg;

    // Pipeline depth; the last stage is the output register
    localparam int unsigned NUM_STAGES = 10;

    // Opcodes carried on s_tuser
    localparam logic OP_DATE_TO_JDN = 1'b0;
    localparam logic OP_JDN_TO_DATE = 1'b1;

    // Calendar constants
    localparam logic [14:0] JDN_OFFSET_A = 15'd32044;
    localparam logic [24:0] JDN_OFFSET_J = 25'd32045;
    localparam logic [15:0] YEAR_BASE    = 16'd4800;
    localparam logic [25:0] DAYS_400Y    = 26'd146097;
    localparam logic [17:0] DAYS_4Y      = 18'd1461;
    localparam logic [10:0] DAYS_5M      = 11'd153;

    // Reciprocals for the day number split: quotient estimate is exact or one low
    localparam int unsigned DIV1_K = 26;
    localparam logic [8:0]  DIV1_M = 9'((64'd1 << DIV1_K) / 64'd146097);
    localparam int unsigned DIV2_K = 18;
    localparam logic [7:0]  DIV2_M = 8'((64'd1 << DIV2_K) / 64'd1461);
    localparam int unsigned DIV3_K = 11;
    localparam logic [3:0]  DIV3_M = 4'((64'd1 << DIV3_K) / 64'd153);

    // Rounded-up reciprocal of 100, exact for magnitudes below 2^15
    localparam int unsigned Y100_K = 21;
    localparam logic [14:0] Y100_M = 15'(((64'd1 << Y100_K) + 64'd99) / 64'd100);

    // One pipeline word; each stage fills in its own fields
    typedef struct packed {
        logic               op;
        // date to day number
        logic [4:0]         day_in;
        logic [8:0]         mtab;
        logic [15:0]        y;
        logic [14:0]        ymag;
        logic               yneg;
        logic [7:0]         q100;
        logic [24:0]        y365;
        logic [16:0]        lsum;
        logic [22:0]        jdn;
        // day number to date
        logic [25:0]        x1;
        logic [7:0]         b;
        logic [17:0]        r1;
        logic [17:0]        x2;
        logic [6:0]         d;
        logic [10:0]        r2;
        logic [8:0]         e;
        logic [10:0]        x3;
        logic [3:0]         m;
        // results
        logic [22:0]        out_day_number;
        logic [14:0]        out_year;
        logic [3:0]         out_month;
        logic [4:0]         out_day;
    } stage_t;

    // Days before month index m, counting from March: (153*m + 2) / 5
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd398;
            4'd14:   v = 9'd428;
            default: v = 9'd459;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/gregorian_julian_day_convert.sv
// An accepted input word passes through all NUM_STAGES stage registers before its result word shows on m_*.
// Throughput: one word per cycle; the whole pipeline holds while a result word waits
// with m_tready low.
// The depth is set by the three reciprocal divisions of the day number path,
// two stages each (estimate, then multiply back and correct).
// Reset (rst_n low, asynchronous) clears all stage valid bits; payload is not reset.
module gregorian_julian_day_convert
    import gjd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // in_year[14:0], in_month[18:15], in_day[23:19], in_day_number[46:24], zero pad [47]
    input  logic [47:0] s_tdata,
    // opcode[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_day_number[22:0], out_year[37:23], out_month[41:38], out_day[46:42], zero [47]
    output logic [47:0] m_tdata
);

    stage_t                  st_reg  [NUM_STAGES];
    stage_t                  st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]   vld_reg;
    logic [NUM_STAGES-1:0]   vld_next;
    logic                    adv;

    // Stage locals
    logic [14:0] in_year;
    logic [3:0]  in_month;
    logic        a_early;
    logic [3:0]  mon_idx;
    logic [15:0] y1;
    logic [29:0] p100;
    logic [12:0] mag4;
    logic [12:0] mag;
    logic [24:0] jsum;
    logic [23:0] a_jdn;
    logic [34:0] p1;
    logic [25:0] prod1;
    logic [25:0] r0a;
    logic [25:0] r0b;
    logic [25:0] p2;
    logic [17:0] prod2;
    logic [17:0] r2a;
    logic [17:0] r2b;
    logic [11:0] t4e;
    logic [14:0] p3;
    logic [10:0] prod3;
    logic [10:0] r3;
    logic        late;
    logic [9:0]  day_w;
    logic [16:0] yr17;

    // Advance whenever the output register is empty or being drained
    assign adv      = !vld_reg[NUM_STAGES-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = {1'b0, st_reg[NUM_STAGES-1].out_day, st_reg[NUM_STAGES-1].out_month,
                       st_reg[NUM_STAGES-1].out_year, st_reg[NUM_STAGES-1].out_day_number};

    assign in_year  = s_tdata[14:0];
    assign in_month = s_tdata[18:15];

    // Shift valid bits along with the data
    always_comb
    begin
        vld_next[0] = s_tvalid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    // Stage logic
    always_comb
    begin
        // Stage 1: shift the year to March, offset the day number
        st_next[0]        = '0;
        st_next[0].op     = s_tuser;
        st_next[0].day_in = s_tdata[23:19];
        a_early           = (in_month <= 4'd2);
        mon_idx           = a_early ? 4'(in_month + 4'd9) : 4'(in_month - 4'd3);
        st_next[0].mtab   = days_before(mon_idx);
        y1                = {in_year[14], in_year} + YEAR_BASE - 16'(a_early);
        st_next[0].y      = y1;
        st_next[0].yneg   = y1[15];
        st_next[0].ymag   = y1[15] ? 15'(-y1) : y1[14:0];
        a_jdn             = {1'b0, s_tdata[46:24]} + 24'(JDN_OFFSET_A);
        st_next[0].x1     = {a_jdn, 2'b11};

        // Stage 2: year / 100 by reciprocal; first quotient estimate
        st_next[1]        = st_reg[0];
        p100              = 30'(st_reg[0].ymag) * 30'(Y100_M);
        st_next[1].q100   = p100[Y100_K +: 8];
        p1                = 35'(st_reg[0].x1) * 35'(DIV1_M);
        st_next[1].b      = p1[DIV1_K +: 8];

        // Stage 3: leap terms and 365 * y; correct the 400-year count
        st_next[2]        = st_reg[1];
        mag4              = 13'(st_reg[1].ymag >> 2);
        mag               = mag4 - 13'(st_reg[1].q100) + 13'(st_reg[1].q100 >> 2);
        st_next[2].lsum   = st_reg[1].yneg ? 17'(-{4'd0, mag}) : {4'd0, mag};
        st_next[2].y365   = {{9{st_reg[1].y[15]}}, st_reg[1].y} * 25'd365;
        prod1             = 26'(st_reg[1].b) * DAYS_400Y;
        r0a               = st_reg[1].x1 - prod1;
        r0b               = r0a - DAYS_400Y;
        if (r0a >= DAYS_400Y)
        begin
            st_next[2].b  = st_reg[1].b + 8'd1;
            st_next[2].r1 = r0b[17:0];
        end
        else
        begin
            st_next[2].r1 = r0a[17:0];
        end

        // Stage 4: sum the day number; form 4c + 3 for the 4-year split
        st_next[3]        = st_reg[2];
        jsum              = 25'(st_reg[2].day_in) + 25'(st_reg[2].mtab) + st_reg[2].y365
                            + {{8{st_reg[2].lsum[16]}}, st_reg[2].lsum} - JDN_OFFSET_J;
        st_next[3].jdn    = jsum[22:0];
        st_next[3].x2     = st_reg[2].r1 + 18'(st_reg[2].b[1:0]);

        // Stage 5: 4-year quotient estimate
        st_next[4]        = st_reg[3];
        p2                = 26'(st_reg[3].x2) * 26'(DIV2_M);
        st_next[4].d      = p2[DIV2_K +: 7];

        // Stage 6: correct the 4-year count
        st_next[5]        = st_reg[4];
        prod2             = 18'(st_reg[4].d) * DAYS_4Y;
        r2a               = st_reg[4].x2 - prod2;
        r2b               = r2a - DAYS_4Y;
        if (r2a >= DAYS_4Y)
        begin
            st_next[5].d  = st_reg[4].d + 7'd1;
            st_next[5].r2 = r2b[10:0];
        end
        else
        begin
            st_next[5].r2 = r2a[10:0];
        end

        // Stage 7: day of the March-based year, then 5e + 2
        st_next[6]        = st_reg[5];
        t4e               = 12'(st_reg[5].r2) + 12'(st_reg[5].d[1:0]);
        st_next[6].e      = t4e[10:2];
        st_next[6].x3     = {t4e[10:2], 2'b00} + 11'(t4e[10:2]) + 11'd2;

        // Stage 8: month quotient estimate
        st_next[7]        = st_reg[6];
        p3                = 15'(st_reg[6].x3) * 15'(DIV3_M);
        st_next[7].m      = p3[DIV3_K +: 4];

        // Stage 9: correct the month index
        st_next[8]        = st_reg[7];
        prod3             = 11'(st_reg[7].m) * DAYS_5M;
        r3                = st_reg[7].x3 - prod3;
        if (r3 >= DAYS_5M)
        begin
            st_next[8].m  = st_reg[7].m + 4'd1;
        end

        // Stage 10: assemble the result word, zero the fields the opcode leaves unused
        st_next[9]        = st_reg[8];
        late              = (st_reg[8].m >= 4'd10);
        day_w             = 10'(st_reg[8].e) - 10'(days_before(st_reg[8].m)) + 10'd1;
        yr17              = 17'(st_reg[8].b) * 17'd100 + 17'(st_reg[8].d) + 17'(late)
                            - 17'(YEAR_BASE);
        if (st_reg[8].op == OP_JDN_TO_DATE)
        begin
            st_next[9].out_day_number = '0;
            st_next[9].out_year       = yr17[14:0];
            st_next[9].out_month      = late ? 4'(st_reg[8].m - 4'd9)
                                             : 4'(st_reg[8].m + 4'd3);
            st_next[9].out_day        = day_w[4:0];
        end
        else
        begin
            st_next[9].out_day_number = st_reg[8].jdn;
            st_next[9].out_year       = '0;
            st_next[9].out_month      = '0;
            st_next[9].out_day        = '0;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Payload; hold on stall
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

endmodule

// File: rtl/core/gjd_checker.sv
module gjd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // No result word shows while reset is applied
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result word valid during reset");

    // Input side stalls exactly when a result word waits
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output drain");

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // Day number and date fields are never both in use
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[22:0] != 23'd0) |-> (m_tdata[47:23] == 25'd0))
        else $error("day number and date fields both nonzero");

endmodule

bind gregorian_julian_day_convert gjd_checker u_gjd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
